/* sv/mse_pkg.sv */
// Package: types, codes and constants shared by the execute unit modules.
`timescale 1ns / 1ps
package mse_pkg;

    typedef enum logic [4:0] {
        ACT_ADD = 5'd0, ACT_ADDU = 5'd1, ACT_SUB = 5'd2, ACT_SUBU = 5'd3,
        ACT_MULT = 5'd4, ACT_MULTU = 5'd5, ACT_DIV = 5'd6, ACT_DIVU = 5'd7,
        ACT_AND = 5'd8, ACT_NOR = 5'd9, ACT_OR = 5'd10, ACT_XOR = 5'd11,
        ACT_NOT = 5'd12, ACT_LW = 5'd13, ACT_LI = 5'd14, ACT_LA = 5'd15,
        ACT_SW = 5'd16, ACT_MOVE = 5'd17, ACT_MFHI = 5'd18, ACT_MFLO = 5'd19,
        ACT_J = 5'd20, ACT_BEQ = 5'd21, ACT_BNE = 5'd22, ACT_BLT = 5'd23,
        ACT_BLE = 5'd24, ACT_BGT = 5'd25, ACT_BGE = 5'd26, ACT_NOP = 5'd27,
        ACT_RESTART = 5'd28
    } t_action;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_DIV0    = 3'd1;
    localparam logic [2:0] ST_OVF     = 3'd2;
    localparam logic [2:0] ST_UNKNOWN = 3'd3;
    localparam logic [2:0] ST_MEM     = 3'd4;

    localparam logic CFG_PROGRAM_LAST = 1'b0;
    localparam logic CFG_START_PC     = 1'b1;

    typedef struct packed {
        logic [4:0]  action;
        logic [4:0]  dest_reg;
        logic [4:0]  src_a_reg;
        logic        src_a_is_imm;
        logic [4:0]  src_b_reg;
        logic        src_b_is_imm;
        logic [31:0] immediate;
        logic [9:0]  target;
    } t_in_beat;

    typedef struct packed {
        logic [9:0]  next_pc;
        logic [2:0]  status;
        logic        reg_written;
        logic [4:0]  written_reg;
        logic [31:0] written_value;
        logic [31:0] hi_value;
        logic [31:0] lo_value;
    } t_out_beat;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_READ, S_EXEC, S_ITER, S_MEMR, S_DONE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic clr_step;   // clear one memory word
        logic capture;    // latch input beat
        logic read_ops;   // register file read
        logic exec;       // decide and start the instruction
        logic iter;       // one multiply/divide step
        logic finish_md;  // write back hi/lo
        logic finish_ld;  // write back load data or commit a store
        logic emit;       // load the output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clr_done;
        logic need_iter;  // started a multiply/divide
        logic need_mem;   // started a load or store
        logic iter_last;
    } t_sts;

endpackage

/* sv/mse_datapath.sv */
// Datapath: register file, data memory, hi/lo, pc and shift-add/subtract unit.
`timescale 1ns / 1ps
module mse_datapath #(
    parameter int MEM_BYTES  = 512,
    parameter int PROG_DEPTH = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mse_pkg::t_cmd      i_cmd,
    output mse_pkg::t_sts      o_sts,
    input  mse_pkg::t_in_beat  i_beat,
    input  logic [9:0]         i_program_last,
    input  logic [9:0]         i_start_pc,
    output mse_pkg::t_out_beat o_beat
);
    import mse_pkg::*;

    localparam int WORDS = MEM_BYTES / 4;
    localparam int WAW   = $clog2(WORDS);
    localparam int PW    = $clog2(PROG_DEPTH);

    logic [31:0] r_rf [32];
    logic [31:0] r_mem [WORDS];
    t_in_beat    r_in;
    logic [31:0] r_a, r_b, r_rb;
    logic [31:0] r_hi, r_lo;
    logic [PW-1:0] r_pc;
    logic [WAW:0]  r_clr;
    logic [31:0] r_mem_q0, r_mem_q1;
    logic [1:0]  r_boff;
    logic        r_ld_bad;
    t_out_beat   r_out;

    // multiply/divide unit state
    logic [63:0] r_acc;
    logic [31:0] r_opb;
    logic [5:0]  r_cnt;
    logic        r_is_div, r_neg_q, r_neg_r, r_mul_neg;

    assign o_beat = r_out;

    // operand read stage
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in <= i_beat;
        end
        if (i_cmd.read_ops) begin
            r_rb <= (r_in.src_b_reg == 5'd0) ? 32'd0 : r_rf[r_in.src_b_reg];
            r_a  <= r_in.src_a_is_imm ? r_in.immediate
                  : ((r_in.src_a_reg == 5'd0) ? 32'd0 : r_rf[r_in.src_a_reg]);
            r_b  <= r_in.src_b_is_imm ? r_in.immediate
                  : ((r_in.src_b_reg == 5'd0) ? 32'd0 : r_rf[r_in.src_b_reg]);
        end
    end

    // execute-stage combinational decode
    logic [31:0] n_addr, n_sum, n_dif;
    logic        n_addr_ok, n_add_ovf, n_sub_ovf;
    logic [PW-1:0] n_adv, n_tgt, n_start;
    logic        n_cond;
    t_action     n_act;

    assign n_act     = t_action'(r_in.action);
    assign n_addr    = r_in.immediate + (r_in.src_b_is_imm ? 32'd0 : r_rb);
    assign n_addr_ok = n_addr <= 32'(MEM_BYTES - 4);
    assign n_sum     = r_a + r_b;
    assign n_dif     = r_a - r_b;
    assign n_add_ovf = (r_a[31] ~^ r_b[31]) & (n_sum[31] ^ r_a[31]);
    assign n_sub_ovf = (r_a[31] ^ r_b[31]) & (n_dif[31] ^ r_a[31]);
    assign n_adv     = ({{(32-PW){1'b0}}, r_pc} < {22'd0, i_program_last})
                       ? r_pc + 1'b1 : r_pc;
    assign n_tgt     = PW'(r_in.target);
    assign n_start   = PW'(i_start_pc);

    always_comb begin
        case (n_act)
            ACT_BEQ: n_cond = r_a == r_b;
            ACT_BNE: n_cond = r_a != r_b;
            ACT_BLT: n_cond = r_a < r_b;
            ACT_BLE: n_cond = r_a <= r_b;
            ACT_BGT: n_cond = r_a > r_b;
            default: n_cond = r_a >= r_b;
        endcase
    end

    logic [31:0] n_ma, n_mb;
    assign n_ma = (n_act == ACT_DIV && r_a[31]) ? 32'd0 - r_a : r_a;
    assign n_mb = (n_act == ACT_DIV && r_b[31]) ? 32'd0 - r_b : r_b;

    // one step of shift-add multiply or restoring divide
    // the bit shifted out of the top joins the compare as bit 32
    logic [32:0] n_dsub;
    logic [63:0] n_dsh;
    logic [32:0] n_madd;
    assign n_dsh  = {r_acc[62:0], 1'b0};
    assign n_dsub = {r_acc[63], n_dsh[63:32]} - {1'b0, r_opb};
    assign n_madd = {1'b0, r_acc[63:32]} + (r_acc[0] ? {1'b0, r_opb} : 33'd0);

    logic [31:0] n_q, n_rm;
    logic [63:0] n_prod;
    assign n_q    = r_neg_q ? 32'd0 - r_acc[31:0] : r_acc[31:0];
    assign n_rm   = r_neg_r ? 32'd0 - r_acc[63:32] : r_acc[63:32];
    assign n_prod = r_mul_neg ? 64'd0 - r_acc : r_acc;

    assign o_sts.clr_done  = r_clr == WAW'(0) + (WAW+1)'(WORDS - 1);
    assign o_sts.iter_last = r_cnt == 6'd1;

    logic n_need_iter, n_need_mem;
    always_comb begin
        n_need_iter = 1'b0;
        n_need_mem  = 1'b0;
        case (n_act)
            ACT_MULT, ACT_MULTU: n_need_iter = 1'b1;
            ACT_DIV, ACT_DIVU:   n_need_iter = r_b != 32'd0;
            ACT_LW:              n_need_mem  = 1'b1;
            default: ;
        endcase
    end
    assign o_sts.need_iter = n_need_iter;

    // aligned words holding the load bytes
    logic [WAW-1:0] n_w0, n_w1;
    assign n_w0 = n_addr[WAW+1:2];
    assign n_w1 = n_w0 + 1'b1;

    // main state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hi  <= '0;
            r_lo  <= '0;
            r_pc  <= '0;
            r_clr <= '0;
            for (int k = 0; k < 32; k++) r_rf[k] <= '0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.exec) begin
                r_out.status        <= ST_OK;
                r_out.reg_written   <= 1'b0;
                r_out.written_reg   <= '0;
                r_out.written_value <= '0;
                case (n_act)
                    ACT_ADD, ACT_SUB: begin
                        if ((n_act == ACT_ADD) ? n_add_ovf : n_sub_ovf) begin
                            r_out.status <= ST_OVF;
                        end else begin
                            r_out.written_value <= (n_act == ACT_ADD) ? n_sum : n_dif;
                            r_out.reg_written   <= 1'b1;
                            r_pc <= n_adv;
                        end
                    end
                    ACT_ADDU: begin r_out.written_value <= n_sum;
                        r_out.reg_written <= 1'b1; r_pc <= n_adv; end
                    ACT_SUBU: begin r_out.written_value <= n_dif;
                        r_out.reg_written <= 1'b1; r_pc <= n_adv; end
                    ACT_AND: begin r_out.written_value <= r_a & r_b;
                        r_out.reg_written <= 1'b1; r_pc <= n_adv; end
                    ACT_NOR: begin r_out.written_value <= ~(r_a | r_b);
                        r_out.reg_written <= 1'b1; r_pc <= n_adv; end
                    ACT_OR: begin r_out.written_value <= r_a | r_b;
                        r_out.reg_written <= 1'b1; r_pc <= n_adv; end
                    ACT_XOR: begin r_out.written_value <= r_a ^ r_b;
                        r_out.reg_written <= 1'b1; r_pc <= n_adv; end
                    ACT_NOT: begin r_out.written_value <= ~r_a;
                        r_out.reg_written <= 1'b1; r_pc <= n_adv; end
                    ACT_LI, ACT_MOVE: begin r_out.written_value <= r_a;
                        r_out.reg_written <= 1'b1; r_pc <= n_adv; end
                    ACT_LA: begin r_out.written_value <= n_addr;
                        r_out.reg_written <= 1'b1; r_pc <= n_adv; end
                    ACT_MFHI: begin r_out.written_value <= r_hi;
                        r_out.reg_written <= 1'b1; r_pc <= n_adv; end
                    ACT_MFLO: begin r_out.written_value <= r_lo;
                        r_out.reg_written <= 1'b1; r_pc <= n_adv; end
                    ACT_LW: begin
                        r_out.reg_written <= 1'b1;
                        if (!n_addr_ok) r_out.status <= ST_MEM;
                        r_pc <= n_adv;
                    end
                    ACT_SW: begin
                        if (!n_addr_ok) r_out.status <= ST_MEM;
                        r_pc <= n_adv;
                    end
                    ACT_MULT, ACT_MULTU: r_pc <= n_adv;
                    ACT_DIV, ACT_DIVU: begin
                        if (r_b == 32'd0) r_out.status <= ST_DIV0;
                        else r_pc <= n_adv;
                    end
                    ACT_J: begin
                        if ({{(32-PW){1'b0}}, n_tgt} < {22'd0, i_program_last})
                            r_pc <= n_tgt;
                    end
                    ACT_BEQ, ACT_BNE, ACT_BLT, ACT_BLE, ACT_BGT, ACT_BGE:
                        r_pc <= n_cond ? n_tgt : n_adv;
                    ACT_NOP:     r_pc <= n_adv;
                    ACT_RESTART: r_pc <= n_start;
                    default:     r_out.status <= ST_UNKNOWN;
                endcase
                if (r_in.dest_reg == 5'd0) begin
                    r_out.reg_written   <= 1'b0;
                end
                r_out.written_reg <= r_in.dest_reg;
            end
            if (i_cmd.finish_md) begin
                if (r_is_div) begin
                    r_lo <= n_q;
                    r_hi <= n_rm;
                end else begin
                    r_lo <= n_prod[31:0];
                    r_hi <= n_prod[63:32];
                end
            end
            if (i_cmd.emit) begin
                r_out.next_pc <= 10'(r_pc);
                r_out.hi_value <= r_hi;
                r_out.lo_value <= r_lo;
                if (!r_out.reg_written) begin
                    r_out.written_reg   <= '0;
                    r_out.written_value <= '0;
                end else begin
                    r_rf[r_out.written_reg] <= r_out.written_value;
                end
            end
            if (i_cmd.finish_ld && !r_ld_bad) begin
                case (r_boff)
                    2'd0: r_out.written_value <= r_mem_q0;
                    2'd1: r_out.written_value <= {r_mem_q1[7:0], r_mem_q0[31:8]};
                    2'd2: r_out.written_value <= {r_mem_q1[15:0], r_mem_q0[31:16]};
                    default: r_out.written_value <= {r_mem_q1[23:0], r_mem_q0[31:24]};
                endcase
            end
        end
    end

    // data memory as 32-bit words; unaligned access spans two words
    logic [31:0] n_wd0, n_wd1, n_old0, n_old1;
    logic [63:0] n_cat;
    logic        r_st_pend;
    logic [1:0]  r_st_off;
    logic [WAW-1:0] r_st_w0;
    logic [31:0] r_st_data;
    assign n_old0 = r_mem_q0;
    assign n_old1 = r_mem_q1;
    always_comb begin
        n_cat = {n_old1, n_old0};
        case (r_st_off)
            2'd0: n_cat[31:0]  = r_st_data;
            2'd1: n_cat[39:8]  = r_st_data;
            2'd2: n_cat[47:16] = r_st_data;
            default: n_cat[55:24] = r_st_data;
        endcase
        n_wd0 = n_cat[31:0];
        n_wd1 = n_cat[63:32];
    end

    // store runs as read-modify-write through the load path
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            r_mem[r_clr[WAW-1:0]] <= '0;
        end else if (i_cmd.finish_ld && r_st_pend) begin
            r_mem[r_st_w0] <= n_wd0;
            if (r_st_off != 2'd0) r_mem[r_st_w0 + 1'b1] <= n_wd1;
        end
        if (i_cmd.exec) begin
            r_mem_q0 <= r_mem[n_w0];
            r_mem_q1 <= r_mem[n_w1];
            r_boff   <= n_addr[1:0];
            r_ld_bad <= !n_addr_ok;
            r_st_pend <= (n_act == ACT_SW) && n_addr_ok;
            r_st_off  <= n_addr[1:0];
            r_st_w0   <= n_w0;
            r_st_data <= r_a;
        end
    end
    assign o_sts.need_mem = n_need_mem | (n_act == ACT_SW);

    // multiply/divide sequencing
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_cnt     <= 6'd32;
            r_is_div  <= (n_act == ACT_DIV) || (n_act == ACT_DIVU);
            r_opb     <= n_mb;
            r_acc     <= {32'd0, n_ma};
            r_neg_q   <= (n_act == ACT_DIV) && (r_a[31] ^ r_b[31]);
            r_neg_r   <= (n_act == ACT_DIV) && r_a[31];
            r_mul_neg <= 1'b0;
            if (n_act == ACT_MULT) begin
                r_acc     <= {32'd0, r_a[31] ? 32'd0 - r_a : r_a};
                r_opb     <= r_b[31] ? 32'd0 - r_b : r_b;
                r_mul_neg <= r_a[31] ^ r_b[31];
            end
        end else if (i_cmd.iter) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_is_div) begin
                if (!n_dsub[32]) r_acc <= {n_dsub[31:0], n_dsh[31:1], 1'b1};
                else             r_acc <= n_dsh;
            end else begin
                r_acc <= {n_madd, r_acc[31:1]};
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.iter |-> r_cnt != 6'd0)
        else $error("multiply/divide step past its count");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit && r_out.reg_written |-> r_out.written_reg != 5'd0)
        else $error("write to register zero reported");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish_md |-> $past(i_cmd.iter))
        else $error("hi/lo written before the unit finished");
endmodule

/* sv/mse_control.sv */
// Controller: sequencing of clear, read, execute, iterate and result stages.
`timescale 1ns / 1ps
module mse_control (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  mse_pkg::t_sts i_sts,
    output mse_pkg::t_cmd o_cmd
);
    import mse_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   r_md_fin;

    assign o_out_valid = r_out_valid;
    // input waits while busy or while a held result still occupies the output
    assign o_in_stall  = (r_state != S_IDLE) || (r_out_valid && i_out_stall);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (i_sts.clr_done) n_state = S_IDLE;
            S_IDLE:  if (i_in_valid && !o_in_stall) n_state = S_READ;
            S_READ:  n_state = S_EXEC;
            S_EXEC: begin
                if (i_sts.need_iter)     n_state = S_ITER;
                else if (i_sts.need_mem) n_state = S_MEMR;
                else                     n_state = S_DONE;
            end
            S_ITER:  if (i_sts.iter_last) n_state = S_DONE;
            S_MEMR:  n_state = S_DONE;
            S_DONE: begin
                if (!r_md_fin && (!r_out_valid || !i_out_stall)) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // command outputs; hi/lo write-back comes before the result is emitted
    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_CLEAR: o_cmd.clr_step = 1'b1;
            S_IDLE:  o_cmd.capture  = i_in_valid && !o_in_stall;
            S_READ:  o_cmd.read_ops = 1'b1;
            S_EXEC:  o_cmd.exec     = 1'b1;
            S_ITER: begin
                o_cmd.iter      = 1'b1;
            end
            S_MEMR:  o_cmd.finish_ld = 1'b1;
            S_DONE: begin
                o_cmd.finish_md = r_md_fin;
                o_cmd.emit      = !r_md_fin && (!r_out_valid || !i_out_stall);
            end
            default: ;
        endcase
    end

    // finish_md is raised on the cycle after the last step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
            r_md_fin    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_md_fin <= (r_state == S_ITER) && i_sts.iter_last;
            if (o_cmd.emit)               r_out_valid <= 1'b1;
            else if (!i_out_stall)        r_out_valid <= 1'b0;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> o_in_stall)
        else $error("input taken during memory clear");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> !(r_out_valid && i_out_stall))
        else $error("result overwritten while stalled");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_md_fin) |-> r_state == S_DONE)
        else $error("hi/lo write-back out of order");
endmodule

/* sv/mips_subset_execute_unit.sv */
// Top level: execute unit for a predecoded 32-bit integer instruction subset.
`timescale 1ns / 1ps
// channel | direction | handshake             | beat
// in      | input     | i_in_valid/o_in_stall | mse_pkg::t_in_beat
// out     | output    | o_out_valid/i_out_stall| mse_pkg::t_out_beat
// cfg     | input     | i_cfg_valid/o_cfg_ready| index 1 bit, data 10 bits
// Simple instructions and divide by zero go through the read, execute and
// result states; loads and stores add a memory state; multiply and divide
// add 32 steps of the one-bit-a-step shift-add/subtract unit and a hi/lo
// write-back step. After reset the data memory is cleared one word a cycle,
// all MEM_BYTES/4 words, before the first beat is taken.
// A result is held in the output register while out is stalled; the next
// input beat is taken once that register is free.
module mips_subset_execute_unit #(
    parameter int MEM_BYTES  = 512,
    parameter int PROG_DEPTH = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  mse_pkg::t_in_beat  i_in_beat,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output mse_pkg::t_out_beat o_out_beat,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [9:0]         i_cfg_data
);
    import mse_pkg::*;

    t_cmd       w_cmd;
    t_sts       w_sts;
    logic [9:0] r_program_last, r_start_pc;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_program_last <= '0;
            r_start_pc     <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PROGRAM_LAST: r_program_last <= i_cfg_data;
                CFG_START_PC:     r_start_pc     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    mse_control u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .i_sts(w_sts), .o_cmd(w_cmd)
    );

    mse_datapath #(.MEM_BYTES(MEM_BYTES), .PROG_DEPTH(PROG_DEPTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd(w_cmd), .o_sts(w_sts), .i_beat(i_in_beat),
        .i_program_last(r_program_last), .i_start_pc(r_start_pc),
        .o_beat(o_out_beat)
    );
endmodule

/* dv/mips_subset_execute_unit_tb.sv */
// Testbench for the MIPS subset execute unit: self-checking, randomised, with back-pressure.
`timescale 1ns / 1ps
module mips_subset_execute_unit_tb;
    import mse_pkg::*;

    localparam int MEM_SIZE  = 512;
    localparam int CYCLE_CAP = 1000000;
    localparam int DRAIN_CYC = 60;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    t_in_beat   i_in_beat = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_out_beat  o_out_beat;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic       i_cfg_index = 1'b0;
    logic [9:0] i_cfg_data = '0;

    mips_subset_execute_unit dut (.*);

    always #1 i_clk = ~i_clk;

    // Shadow architectural state
    logic [31:0] gpr [32];
    logic [31:0] hi_q, lo_q;
    logic [9:0]  pc_q, last_q, entry_q;
    logic [7:0]  dmem [MEM_SIZE];

    t_out_beat exp_results [$];
    int        fail_cnt = 0;
    int        cycles = 0;
    bit        no_gaps = 0;
    int        hold_req = 0;

    // Timeout guard
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [31:0] rd(logic [4:0] r);
        return (r == 0) ? 32'd0 : gpr[r];
    endfunction

    function automatic void step_pc();
        if (pc_q < last_q) pc_q = pc_q + 10'd1;
    endfunction

    // Executes one instruction on the shadow state and returns the result beat
    function automatic t_out_beat execute_instr(t_in_beat b);
        t_out_beat   o;
        logic [31:0] a, bv, addr, r, val, ma, mb, q, rm;
        logic [63:0] p;
        logic        wr, cond;
        logic [2:0]  st;
        a    = b.src_a_is_imm ? b.immediate : rd(b.src_a_reg);
        bv   = b.src_b_is_imm ? b.immediate : rd(b.src_b_reg);
        addr = b.immediate + (b.src_b_is_imm ? 32'd0 : rd(b.src_b_reg));
        wr = 0; val = 0; st = ST_OK; cond = 0;
        case (b.action)
            ACT_ADD: begin
                r = a + bv;
                if (((a ^ r) & (bv ^ r)) >> 31) st = ST_OVF;
                else begin wr = 1; val = r; step_pc(); end
            end
            ACT_SUB: begin
                r = a - bv;
                if (((a ^ bv) & (a ^ r)) >> 31) st = ST_OVF;
                else begin wr = 1; val = r; step_pc(); end
            end
            ACT_ADDU: begin wr = 1; val = a + bv; step_pc(); end
            ACT_SUBU: begin wr = 1; val = a - bv; step_pc(); end
            ACT_MULT: begin
                p = longint'($signed(a)) * longint'($signed(bv));
                lo_q = p[31:0]; hi_q = p[63:32]; step_pc();
            end
            ACT_MULTU: begin
                p = {32'd0, a} * {32'd0, bv};
                lo_q = p[31:0]; hi_q = p[63:32]; step_pc();
            end
            ACT_DIV: begin
                if (bv == 0) st = ST_DIV0;
                else begin
                    ma = a[31] ? -a : a;
                    mb = bv[31] ? -bv : bv;
                    q = ma / mb; rm = ma % mb;
                    if (a[31] ^ bv[31]) q = -q;
                    if (a[31]) rm = -rm;
                    lo_q = q; hi_q = rm; step_pc();
                end
            end
            ACT_DIVU: begin
                if (bv == 0) st = ST_DIV0;
                else begin lo_q = a / bv; hi_q = a % bv; step_pc(); end
            end
            ACT_AND: begin wr = 1; val = a & bv; step_pc(); end
            ACT_NOR: begin wr = 1; val = ~(a | bv); step_pc(); end
            ACT_OR:  begin wr = 1; val = a | bv; step_pc(); end
            ACT_XOR: begin wr = 1; val = a ^ bv; step_pc(); end
            ACT_NOT: begin wr = 1; val = ~a; step_pc(); end
            ACT_LW: begin
                wr = 1;
                if (addr <= MEM_SIZE - 4)
                    val = {dmem[addr+3], dmem[addr+2], dmem[addr+1], dmem[addr]};
                else st = ST_MEM;
                step_pc();
            end
            ACT_LI, ACT_MOVE: begin wr = 1; val = a; step_pc(); end
            ACT_LA: begin wr = 1; val = addr; step_pc(); end
            ACT_SW: begin
                if (addr <= MEM_SIZE - 4)
                    for (int k = 0; k < 4; k++) dmem[addr+k] = a[8*k +: 8];
                else st = ST_MEM;
                step_pc();
            end
            ACT_MFHI: begin wr = 1; val = hi_q; step_pc(); end
            ACT_MFLO: begin wr = 1; val = lo_q; step_pc(); end
            ACT_J: if (b.target < last_q) pc_q = b.target;
            ACT_BEQ, ACT_BNE, ACT_BLT, ACT_BLE, ACT_BGT, ACT_BGE: begin
                case (b.action)
                    ACT_BEQ: cond = (a == bv);
                    ACT_BNE: cond = (a != bv);
                    ACT_BLT: cond = (a < bv);
                    ACT_BLE: cond = (a <= bv);
                    ACT_BGT: cond = (a > bv);
                    default: cond = (a >= bv);
                endcase
                if (cond) pc_q = b.target; else step_pc();
            end
            ACT_NOP: step_pc();
            ACT_RESTART: pc_q = entry_q;
            default: st = ST_UNKNOWN;
        endcase
        if (wr && b.dest_reg == 0) begin wr = 0; val = 0; end
        if (wr) gpr[b.dest_reg] = val;
        o.next_pc       = pc_q;
        o.status        = st;
        o.reg_written   = wr;
        o.written_reg   = wr ? b.dest_reg : 5'd0;
        o.written_value = val;
        o.hi_value      = hi_q;
        o.lo_value      = lo_q;
        return o;
    endfunction

    // Result checker
    always @(posedge i_clk) begin
        t_out_beat e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (exp_results.size() == 0) begin
                $error("result beat with nothing expected");
                fail_cnt++;
            end else begin
                e = exp_results.pop_front();
                if (o_out_beat.next_pc !== e.next_pc) begin
                    $error("next_pc exp %0d got %0d", e.next_pc, o_out_beat.next_pc);
                    fail_cnt++;
                end
                if (o_out_beat.status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, o_out_beat.status);
                    fail_cnt++;
                end
                if (o_out_beat.reg_written !== e.reg_written) begin
                    $error("reg_written exp %0d got %0d", e.reg_written,
                           o_out_beat.reg_written);
                    fail_cnt++;
                end
                if (o_out_beat.written_reg !== e.written_reg) begin
                    $error("written_reg exp %0d got %0d", e.written_reg,
                           o_out_beat.written_reg);
                    fail_cnt++;
                end
                if (o_out_beat.written_value !== e.written_value) begin
                    $error("written_value exp %h got %h", e.written_value,
                           o_out_beat.written_value);
                    fail_cnt++;
                end
                if (o_out_beat.hi_value !== e.hi_value) begin
                    $error("hi_value exp %h got %h", e.hi_value, o_out_beat.hi_value);
                    fail_cnt++;
                end
                if (o_out_beat.lo_value !== e.lo_value) begin
                    $error("lo_value exp %h got %h", e.lo_value, o_out_beat.lo_value);
                    fail_cnt++;
                end
            end
        end
    end

    // Receiver: random stall runs, quiet stretches, and long hold-offs on request
    always @(negedge i_clk) begin
        static int run = 0;
        static int hold = 0;
        static int seen = 0;
        static bit stalling = 0;
        if (hold_req != seen) begin
            seen = hold_req;
            hold = 400;
        end
        if (hold > 0) begin
            hold--;
            i_out_stall <= 1'b1;
        end else begin
            if (run == 0) begin
                stalling = ($urandom_range(0, 2) == 0);
                run = stalling ? $urandom_range(1, 6) : $urandom_range(1, 40);
            end
            run--;
            i_out_stall <= stalling;
        end
    end

    // Sends one beat, with bursty gaps; predicts on acceptance
    task automatic send_instr(t_in_beat b);
        static int burst = 0;
        if (burst == 0) begin
            burst = $urandom_range(1, 12);
            if (!no_gaps) repeat ($urandom_range(0, 5)) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
            end
        end
        burst--;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_beat  <= b;
        do @(posedge i_clk); while (o_in_stall);
        exp_results.push_back(execute_instr(b));
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (exp_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic idx, logic [9:0] data);
        wait_idle();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_PROGRAM_LAST) last_q = data; else entry_q = data;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_in_beat mk(t_action act, int d, int ra, bit ai, int rb, bit bi,
                                    logic [31:0] imm, int tgt);
        t_in_beat b;
        b.action = act; b.dest_reg = 5'(d); b.src_a_reg = 5'(ra); b.src_a_is_imm = ai;
        b.src_b_reg = 5'(rb); b.src_b_is_imm = bi; b.immediate = imm;
        b.target = 10'(tgt);
        return b;
    endfunction

    function automatic logic [31:0] rand_imm(bit mem_op);
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return mem_op ? $urandom_range(0, 520) : $urandom_range(0, 255);
            2: case ($urandom_range(0, 4))
                0: return 32'h0;  1: return 32'h1;  2: return 32'h7fffffff;
                3: return 32'h80000000;  default: return 32'hffffffff;
            endcase
            default: return $urandom_range(0, 127) * 4;
        endcase
    endfunction

    function automatic t_in_beat rand_instr();
        t_in_beat b;
        b.action       = ($urandom_range(0, 99) < 3) ? 5'($urandom_range(29, 31))
                                                     : 5'($urandom_range(0, 28));
        b.dest_reg     = 5'($urandom);
        b.src_a_reg    = $urandom_range(0, 7) == 0 ? 5'($urandom) : 5'($urandom_range(0, 7));
        b.src_b_reg    = $urandom_range(0, 7) == 0 ? 5'($urandom) : 5'($urandom_range(0, 7));
        b.src_a_is_imm = 1'($urandom);
        b.src_b_is_imm = 1'($urandom);
        if (b.action inside {ACT_LW, ACT_SW, ACT_LA})
            b.src_b_is_imm = ($urandom_range(0, 9) < 7);
        b.immediate    = rand_imm(b.action inside {ACT_LW, ACT_SW, ACT_LA});
        b.target       = 10'($urandom);
        return b;
    endfunction

    // Directed corners: traps, extremes, memory edges, control flow
    task automatic test_directed();
        send_instr(mk(ACT_LI, 1, 0, 1, 0, 1, 32'h7fffffff, 0));
        send_instr(mk(ACT_LI, 2, 0, 1, 0, 1, 32'h80000000, 0));
        send_instr(mk(ACT_LI, 3, 0, 1, 0, 1, 32'hffffffff, 0));
        send_instr(mk(ACT_ADD, 4, 1, 0, 0, 1, 32'h1, 0));
        send_instr(mk(ACT_SUB, 4, 2, 0, 0, 1, 32'h1, 0));
        send_instr(mk(ACT_ADDU, 4, 1, 0, 1, 0, 0, 0));
        send_instr(mk(ACT_SUBU, 0, 2, 0, 1, 0, 0, 0));
        send_instr(mk(ACT_DIV, 0, 2, 0, 3, 0, 0, 0));
        send_instr(mk(ACT_DIV, 0, 1, 0, 0, 1, 32'h0, 0));
        send_instr(mk(ACT_DIVU, 0, 3, 0, 0, 1, 32'h0, 0));
        send_instr(mk(ACT_DIV, 0, 0, 1, 0, 1, 32'hfffffff9, 0));
        send_instr(mk(ACT_MULT, 0, 2, 0, 3, 0, 0, 0));
        send_instr(mk(ACT_MULTU, 0, 3, 0, 3, 0, 0, 0));
        send_instr(mk(ACT_MFHI, 5, 0, 0, 0, 0, 0, 0));
        send_instr(mk(ACT_MFLO, 6, 0, 0, 0, 0, 0, 0));
        send_instr(mk(ACT_SW, 0, 3, 0, 0, 1, 32'd508, 0));
        send_instr(mk(ACT_LW, 7, 0, 0, 0, 1, 32'd508, 0));
        send_instr(mk(ACT_LW, 7, 0, 0, 0, 1, 32'd509, 0));
        send_instr(mk(ACT_SW, 0, 1, 0, 3, 0, 32'd2, 0));
        send_instr(mk(ACT_LA, 8, 0, 0, 3, 0, 32'd5, 0));
        send_instr(mk(ACT_AND, 9, 1, 0, 2, 0, 0, 0));
        send_instr(mk(ACT_NOR, 9, 1, 0, 2, 0, 0, 0));
        send_instr(mk(ACT_OR, 9, 1, 0, 2, 0, 0, 0));
        send_instr(mk(ACT_XOR, 9, 1, 0, 3, 0, 0, 0));
        send_instr(mk(ACT_NOT, 10, 1, 0, 0, 0, 0, 0));
        send_instr(mk(ACT_MOVE, 11, 3, 0, 0, 0, 0, 0));
        send_instr(mk(ACT_J, 0, 0, 0, 0, 0, 0, 1023));
        send_instr(mk(ACT_J, 0, 0, 0, 0, 0, 0, 500));
        send_instr(mk(ACT_BLT, 0, 1, 0, 2, 0, 0, 7));
        send_instr(mk(ACT_BGE, 0, 3, 0, 2, 0, 0, 9));
        send_instr(mk(ACT_BEQ, 0, 0, 0, 0, 0, 0, 1022));
        send_instr(mk(ACT_NOP, 0, 0, 0, 0, 0, 0, 0));
        send_instr(mk(ACT_RESTART, 0, 0, 0, 0, 0, 0, 0));
        send_instr(t_in_beat'({5'd31, 59'h0}));
    endtask

    task automatic test_random(int n);
        repeat (n) send_instr(rand_instr());
    endtask

    // Receiver holds off while the sender keeps offering beats
    task automatic test_backpressure();
        no_gaps  = 1;
        hold_req = hold_req + 1;
        test_random(60);
        no_gaps = 0;
    endtask

    initial begin
        for (int k = 0; k < 32; k++) gpr[k] = '0;
        for (int k = 0; k < MEM_SIZE; k++) dmem[k] = '0;
        hi_q = '0; lo_q = '0; pc_q = '0; last_q = '0; entry_q = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_random(100);
        cfg_write(CFG_PROGRAM_LAST, 10'd1023);
        cfg_write(CFG_START_PC, 10'd1023);
        test_directed();
        test_random(400);
        test_backpressure();
        cfg_write(CFG_PROGRAM_LAST, 10'd1);
        cfg_write(CFG_START_PC, 10'd0);
        test_random(200);
        cfg_write(CFG_PROGRAM_LAST, 10'($urandom_range(2, 1022)));
        cfg_write(CFG_START_PC, 10'($urandom));
        test_random(400);
        cfg_write(CFG_PROGRAM_LAST, 10'd0);
        test_random(250);
        wait_idle();

        if (fail_cnt == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
